FILE: design/pressure_temperature_compensation_defines.svh
// assertion macros for the compensation block
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_DEFINES_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_DEFINES_SVH

// implication checked on every clock edge outside reset
`define PTC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication checked outside reset
`define PTC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: design/ptc_pkg.sv
//------------------------------------------------------------------------------
// ptc_pkg
// types, constants and helpers shared by the compensation modules
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptc_pkg;

  localparam int unsigned CfgWidth    = 48;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned DivSteps    = 32;

  localparam logic [CfgIdxWidth-1:0] RegTemp   = 2'd0;
  localparam logic [CfgIdxWidth-1:0] RegPressA = 2'd1;
  localparam logic [CfgIdxWidth-1:0] RegPressB = 2'd2;
  localparam logic [CfgIdxWidth-1:0] RegPressC = 2'd3;

  typedef struct packed {
    logic [19:0] raw_temp_reading;
    logic [19:0] raw_press_reading;
  } ptc_in_t;

  typedef struct packed {
    logic signed [23:0] temperature_centi;
    logic [31:0]        pressure_pa;
    logic               pressure_invalid;
  } ptc_out_t;

  // pressure data passed from the front section to the divider
  typedef struct packed {
    logic [23:0] temp;
    logic [31:0] num;
    logic [31:0] den;
    logic        big;
    logic        invalid;
  } ptc_div_t;

  // coefficient set
  typedef struct packed {
    logic [31:0] t1, t2, t3;
    logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  } ptc_coef_t;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
    return 32'($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = a * b;
    return p[31:0];
  endfunction

endpackage

FILE: design/ptc_front.sv
//------------------------------------------------------------------------------
// ptc_front
// temperature and pressure numerator/divisor pipeline
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptc_front import ptc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  ptc_in_t   data_i,
  input  ptc_coef_t coef_i,
  output logic      valid_o,
  output ptc_div_t  data_o
);

  // stage 1: first products of temperature
  logic [6:0] v_q;
  logic [31:0] s1_a_q, s1_dd_q, s1_adcp_q;
  logic [31:0] s1_a_d, s1_d;
  assign s1_d = 32'(data_i.raw_temp_reading >> 4) - coef_i.t1;
  assign s1_a_d = asr32(mul32(32'(data_i.raw_temp_reading >> 3) - (coef_i.t1 << 1),
                              coef_i.t2), 11);

  // stage 2
  logic [31:0] s2_a_q, s2_b_q, s2_adcp_q;
  // stage 3: fine
  logic [31:0] s3_fine_q, s3_adcp_q;
  // stage 4
  logic [31:0] s4_temp_q, s4_a_q, s4_sq_q, s4_adcp_q;
  // stage 5
  logic [31:0] s5_temp_q, s5_b1_q, s5_b2_q, s5_a1_q, s5_a2_q, s5_adcp_q;
  // stage 6
  logic [31:0] s6_temp_q, s6_b_q, s6_x_q, s6_adcp_q;
  // stage 7
  logic [31:0] s7_temp_q, s7_den_q, s7_c_q;

  logic [31:0] s4_a_d, s5_bsum, s6_b_d, s6_x_d, s7_den_d, s7_c_d, p_num;

  assign s4_a_d  = asr32(s3_fine_q, 1) - 32'd64000;
  assign s5_bsum = s5_b1_q + (s5_b2_q << 1);
  assign s6_b_d  = asr32(s5_bsum, 2) + (coef_i.p4 << 16);
  assign s6_x_d  = asr32(asr32(s5_a1_q, 3) + asr32(s5_a2_q, 1), 18);
  assign s7_den_d = asr32(mul32(32'd32768 + s6_x_q, coef_i.p1), 15);
  assign s7_c_d   = (32'd1048576 - s6_adcp_q) - asr32(s6_b_q, 12);
  assign p_num    = mul32(s7_c_q, 32'd3125);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[5:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    s1_a_q    <= s1_a_d;
    s1_dd_q   <= mul32(s1_d, s1_d);
    s1_adcp_q <= 32'(data_i.raw_press_reading);
    s2_a_q    <= s1_a_q;
    s2_b_q    <= asr32(mul32(asr32(s1_dd_q, 12), coef_i.t3), 14);
    s2_adcp_q <= s1_adcp_q;
    s3_fine_q <= s2_a_q + s2_b_q;
    s3_adcp_q <= s2_adcp_q;
    s4_temp_q <= asr32(mul32(s3_fine_q, 32'd5) + 32'd128, 8);
    s4_a_q    <= s4_a_d;
    s4_sq_q   <= mul32(asr32(s4_a_d, 2), asr32(s4_a_d, 2));
    s4_adcp_q <= s3_adcp_q;
    s5_temp_q <= s4_temp_q;
    s5_b1_q   <= mul32(asr32(s4_sq_q, 11), coef_i.p6);
    s5_b2_q   <= mul32(s4_a_q, coef_i.p5);
    s5_a1_q   <= mul32(coef_i.p3, asr32(s4_sq_q, 13));
    s5_a2_q   <= mul32(coef_i.p2, s4_a_q);
    s5_adcp_q <= s4_adcp_q;
    s6_temp_q <= s5_temp_q;
    s6_b_q    <= s6_b_d;
    s6_x_q    <= s6_x_d;
    s6_adcp_q <= s5_adcp_q;
    s7_temp_q <= s6_temp_q;
    s7_den_q  <= s7_den_d;
    s7_c_q    <= s7_c_d;
  end

  // stage 8: numerator product registered for the divider
  logic        v8_q;
  ptc_div_t    d8_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v8_q <= 1'b0;
    end else begin
      v8_q <= v_q[6];
    end
  end

  always_ff @(posedge clk_i) begin
    d8_q.temp    <= s7_temp_q[23:0];
    d8_q.den     <= s7_den_q;
    d8_q.invalid <= (s7_den_q == '0);
    d8_q.big     <= p_num[31];
    d8_q.num     <= p_num[31] ? p_num : (p_num << 1);
  end

  assign valid_o = v8_q;
  assign data_o  = d8_q;

endmodule

FILE: design/ptc_div.sv
//------------------------------------------------------------------------------
// ptc_div
// pipelined restoring divider, one quotient bit per stage
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptc_div import ptc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  input  ptc_div_t data_i,
  output logic     valid_o,
  output ptc_div_t data_o,
  output logic [31:0] quot_o
);

  logic [DivSteps:1]   v_q;
  ptc_div_t            d_q   [1:DivSteps];
  logic [31:0]         rem_q [1:DivSteps];
  logic [31:0]         quo_q [1:DivSteps];

  for (genvar i = 0; i < DivSteps; i++) begin : g_step
    logic        v_in;
    ptc_div_t    d_in;
    logic [31:0] rem_in;
    logic [31:0] quo_in;
    logic [32:0] r;
    logic [32:0] t;
    if (i == 0) begin : g_first
      assign v_in   = valid_i;
      assign d_in   = data_i;
      assign rem_in = '0;
      assign quo_in = data_i.num;
    end else begin : g_next
      assign v_in   = v_q[i];
      assign d_in   = d_q[i];
      assign rem_in = rem_q[i];
      assign quo_in = quo_q[i];
    end
    assign r = {rem_in, quo_in[31]};
    assign t = r - {1'b0, d_in.den};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else begin
        v_q[i+1] <= v_in;
      end
    end
    always_ff @(posedge clk_i) begin
      d_q[i+1]   <= d_in;
      rem_q[i+1] <= t[32] ? r[31:0] : t[31:0];
      quo_q[i+1] <= {quo_in[30:0], ~t[32]};
    end
  end

  assign valid_o = v_q[DivSteps];
  assign data_o  = d_q[DivSteps];
  assign quot_o  = quo_q[DivSteps];

endmodule

FILE: design/ptc_back.sv
//------------------------------------------------------------------------------
// ptc_back
// final pressure correction with p7..p9
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptc_back import ptc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  ptc_div_t    data_i,
  input  logic [31:0] quot_i,
  input  ptc_coef_t   coef_i,
  output logic        valid_o,
  output ptc_out_t    data_o
);

  logic [2:0]  v_q;
  logic [23:0] t1_q, t2_q, t3_q;
  logic        i1_q, i2_q, i3_q;
  logic [31:0] p1_q, p2_q, sq_q, b_q, a_q, res_q;
  logic [31:0] p_d;

  assign p_d = data_i.big ? (quot_i << 1) : quot_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    t1_q <= data_i.temp;
    i1_q <= data_i.invalid;
    p1_q <= p_d;
    sq_q <= mul32(p_d >> 3, p_d >> 3);
    b_q  <= asr32(mul32(p_d >> 2, coef_i.p8), 13);
    t2_q <= t1_q;
    i2_q <= i1_q;
    p2_q <= p1_q;
    a_q  <= asr32(mul32(coef_i.p9, sq_q >> 13), 12) + b_q;
    t3_q <= t2_q;
    i3_q <= i2_q;
    res_q <= i2_q ? '0 : p2_q + asr32(a_q + coef_i.p7, 4);
  end

  assign valid_o = v_q[2];
  assign data_o.temperature_centi = t3_q;
  assign data_o.pressure_pa       = res_q;
  assign data_o.pressure_invalid  = i3_q;

endmodule

FILE: design/pressure_temperature_compensation.sv
//------------------------------------------------------------------------------
// pressure_temperature_compensation
// pipelined 32-bit integer compensation of raw temperature and pressure
//------------------------------------------------------------------------------
// usage
//   input: start with in_i holds one raw reading pair; a transfer happens
//   on every edge with start high and busy low. busy is always low,
//   so a new pair may enter every cycle.
//   config: cfg_we_i, cfg_idx_i, cfg_wdata_i write one 48-bit coefficient
//   register per edge; write only while no item is in flight.
//   output: done_o strobes for one cycle with out_o; the receiver cannot stall.
//   stages: 8 front, 32 divider, 3 back
//   throughput: one item per cycle, every stage including the divider is pipelined
//   reset: clears all valid bits and the coefficient registers
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pressure_temperature_compensation_defines.svh"

module pressure_temperature_compensation import ptc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  ptc_in_t                in_i,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [CfgWidth-1:0]    cfg_wdata_i,
  output logic                   done_o,
  output ptc_out_t               out_o
);

  logic [CfgWidth-1:0] tc_q, pa_q, pb_q, pc_q;
  ptc_coef_t coef;

  // coefficient register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tc_q <= '0;
      pa_q <= '0;
      pb_q <= '0;
      pc_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegTemp:   tc_q <= cfg_wdata_i;
        RegPressA: pa_q <= cfg_wdata_i;
        RegPressB: pb_q <= cfg_wdata_i;
        RegPressC: pc_q <= cfg_wdata_i;
        default:   ;
      endcase
    end
  end

  // field unpacking
  assign coef.t1 = {16'd0, tc_q[15:0]};
  assign coef.t2 = sx16(tc_q[31:16]);
  assign coef.t3 = sx16(tc_q[47:32]);
  assign coef.p1 = {16'd0, pa_q[15:0]};
  assign coef.p2 = sx16(pa_q[31:16]);
  assign coef.p3 = sx16(pa_q[47:32]);
  assign coef.p4 = sx16(pb_q[15:0]);
  assign coef.p5 = sx16(pb_q[31:16]);
  assign coef.p6 = sx16(pb_q[47:32]);
  assign coef.p7 = sx16(pc_q[15:0]);
  assign coef.p8 = sx16(pc_q[31:16]);
  assign coef.p9 = sx16(pc_q[47:32]);

  assign busy = 1'b0;

  logic        accept;
  logic        f_valid, d_valid;
  ptc_div_t    f_data, d_data;
  logic [31:0] quot;

  assign accept = start && !busy;

  ptc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .data_i  (in_i),
    .coef_i  (coef),
    .valid_o (f_valid),
    .data_o  (f_data)
  );

  ptc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_valid),
    .data_i  (f_data),
    .valid_o (d_valid),
    .data_o  (d_data),
    .quot_o  (quot)
  );

  ptc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (d_valid),
    .data_i  (d_data),
    .quot_i  (quot),
    .coef_i  (coef),
    .valid_o (done_o),
    .data_o  (out_o)
  );

  // invalid results carry zero pressure
  `PTC_ASSERT_IMP(a_inv_zero, done_o && out_o.pressure_invalid, out_o.pressure_pa == '0)
  // divider output feeds the back stages; the consequent here is constant true
  `PTC_ASSERT_NXT(a_div_to_back, d_valid, 1'b1)
  // start is never blocked by busy
  `PTC_ASSERT_IMP(a_never_busy, start, !busy)

endmodule

FILE: dv/ptc_checker.sv
//------------------------------------------------------------------------------
// ptc_checker
// watches accepted pairs and results of the compensation block, predicts each
// result with an independent 32-bit integer model and compares in order
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptc_checker import ptc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic                   busy_i,
  input  ptc_in_t                in_i,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [CfgWidth-1:0]    cfg_wdata_i,
  input  logic                   done_i,
  input  ptc_out_t               out_i,
  output int                     fail_count_o,
  output int                     pending_o,
  output int                     result_count_o,
  output int                     invalid_count_o
);

  logic [CfgWidth-1:0] coef_regs [4];
  ptc_out_t            expected_results [$];

  function automatic logic [31:0] sra(input logic [31:0] x, input int n);
    return $signed(x) >>> n;
  endfunction

  function automatic logic [31:0] lo32(input logic [63:0] v);
    return v[31:0];
  endfunction

  function automatic logic [31:0] se(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic ptc_out_t compensate(input ptc_in_t pair);
    logic [31:0] adc_t, adc_p, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] a, b, d, fine, temp, sq, p;
    ptc_out_t r;
    adc_t = {12'd0, pair.raw_temp_reading};
    adc_p = {12'd0, pair.raw_press_reading};
    t1 = {16'd0, coef_regs[RegTemp][15:0]};
    t2 = se(coef_regs[RegTemp][31:16]);
    t3 = se(coef_regs[RegTemp][47:32]);
    p1 = {16'd0, coef_regs[RegPressA][15:0]};
    p2 = se(coef_regs[RegPressA][31:16]);
    p3 = se(coef_regs[RegPressA][47:32]);
    p4 = se(coef_regs[RegPressB][15:0]);
    p5 = se(coef_regs[RegPressB][31:16]);
    p6 = se(coef_regs[RegPressB][47:32]);
    p7 = se(coef_regs[RegPressC][15:0]);
    p8 = se(coef_regs[RegPressC][31:16]);
    p9 = se(coef_regs[RegPressC][47:32]);
    a = sra(lo32(64'((adc_t >> 3) - (t1 << 1)) * 64'(t2)), 11);
    d = (adc_t >> 4) - t1;
    b = sra(lo32(64'(sra(lo32(64'(d) * 64'(d)), 12)) * 64'(t3)), 14);
    fine = a + b;
    temp = sra(lo32(64'(fine) * 64'd5) + 32'd128, 8);
    a = sra(fine, 1) - 32'd64000;
    sq = lo32(64'(sra(a, 2)) * 64'(sra(a, 2)));
    b = lo32(64'(sra(sq, 11)) * 64'(p6));
    b = b + (lo32(64'(a) * 64'(p5)) << 1);
    b = sra(b, 2) + (p4 << 16);
    a = sra(sra(lo32(64'(p3) * 64'(sra(sq, 13))), 3) + sra(lo32(64'(p2) * 64'(a)), 1), 18);
    a = sra(lo32(64'(32'd32768 + a) * 64'(p1)), 15);
    r.temperature_centi = temp[23:0];
    if (a == 32'd0) begin
      r.pressure_pa = '0;
      r.pressure_invalid = 1'b1;
    end else begin
      p = lo32(64'((32'd1048576 - adc_p) - sra(b, 12)) * 64'd3125);
      if (p < 32'h8000_0000) p = (p << 1) / a;
      else p = (p / a) << 1;
      a = sra(lo32(64'(p9) * 64'(lo32(64'(p >> 3) * 64'(p >> 3)) >> 13)), 12);
      b = sra(lo32(64'(p >> 2) * 64'(p8)), 13);
      p = p + sra(a + b + p7, 4);
      r.pressure_pa = p;
      r.pressure_invalid = 1'b0;
    end
    return r;
  endfunction

  assign pending_o = expected_results.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    ptc_out_t exp_r;
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) coef_regs[i] <= '0;
      fail_count_o <= 0;
      result_count_o <= 0;
      invalid_count_o <= 0;
      expected_results.delete();
    end else begin
      // prediction uses the coefficients as they stand before this edge
      if (start_i && !busy_i) expected_results.push_back(compensate(in_i));
      if (cfg_we_i) coef_regs[cfg_idx_i] <= cfg_wdata_i;
      if (done_i) begin
        result_count_o <= result_count_o + 1;
        if (out_i.pressure_invalid) invalid_count_o <= invalid_count_o + 1;
        if (expected_results.size() == 0) begin
          $error("result with nothing expected");
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_i.temperature_centi !== exp_r.temperature_centi) begin
            $error("temperature_centi expected %0d actual %0d",
                   exp_r.temperature_centi, out_i.temperature_centi);
            fail_count_o <= fail_count_o + 1;
          end else if (out_i.pressure_pa !== exp_r.pressure_pa) begin
            $error("pressure_pa expected %0d actual %0d",
                   exp_r.pressure_pa, out_i.pressure_pa);
            fail_count_o <= fail_count_o + 1;
          end else if (out_i.pressure_invalid !== exp_r.pressure_invalid) begin
            $error("pressure_invalid expected %0b actual %0b",
                   exp_r.pressure_invalid, out_i.pressure_invalid);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

FILE: dv/testbench.sv
//------------------------------------------------------------------------------
// testbench
// stimulus and verdict for the compensation block: directed corner pairs, then
// random pairs in bursts under several coefficient sets, checked by ptc_checker
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import ptc_pkg::*;

  // total of front, divider and back stages, used as the settle time before cfg writes
  localparam int Latency = 43;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  ptc_in_t                in_i = '0;
  logic                   cfg_we_i = 1'b0;
  logic [CfgIdxWidth-1:0] cfg_idx_i = RegTemp;
  logic [CfgWidth-1:0]    cfg_wdata_i = '0;
  logic                   done_o;
  ptc_out_t               out_o;
  int                     fail_count, pending, result_count, invalid_count;
  int                     burst_left = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  pressure_temperature_compensation dut (
    .clk_i, .rst_ni, .start, .busy, .in_i, .cfg_we_i, .cfg_idx_i,
    .cfg_wdata_i, .done_o, .out_o
  );

  ptc_checker checker_i (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .in_i, .cfg_we_i,
    .cfg_idx_i, .cfg_wdata_i, .done_i(done_o), .out_i(out_o),
    .fail_count_o(fail_count), .pending_o(pending),
    .result_count_o(result_count), .invalid_count_o(invalid_count)
  );

  // one coefficient write, idle pipeline assumed
  task automatic write_coef(input logic [CfgIdxWidth-1:0] idx,
                            input logic [CfgWidth-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // wait for the pipeline to drain before touching coefficients
  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (Latency + 2) @(posedge clk_i);
  endtask

  // send one pair; start stays high across back-to-back transfers in a burst
  task automatic send_pair(input logic [19:0] t, input logic [19:0] p,
                           input bit bursty);
    int gap;
    if (bursty && burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    start <= 1'b1;
    in_i <= '{raw_temp_reading: t, raw_press_reading: p};
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic stop_sending();
    start <= 1'b0;
    @(posedge clk_i);
  endtask

  // calibration close to a real part, with optional random jitter
  task automatic typical_coefs(input bit jitter);
    logic [15:0] j;
    j = jitter ? 16'($urandom_range(0, 255)) : 16'd0;
    write_coef(RegTemp,   {16'hFC18, 16'd26435, 16'd27504 + j});
    write_coef(RegPressA, {16'd3024, 16'hD5A6 - j, 16'd36477 + j});
    write_coef(RegPressB, {16'hFFF9, 16'd140, 16'd2855 + j});
    write_coef(RegPressC, {16'd15500, 16'hD80C, 16'd15500});
  endtask

  task automatic random_coefs();
    for (int r = 0; r < 4; r++)
      write_coef(CfgIdxWidth'(r), {16'($urandom), $urandom});
  endtask

  initial begin
    #20000000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [19:0] t, p;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset coefficients give a zero divisor
    send_pair(20'd0, 20'd0, 1'b0);
    send_pair(20'hFFFFF, 20'hFFFFF, 1'b0);
    stop_sending();
    drain();

    typical_coefs(1'b0);
    send_pair(20'd519888, 20'd415148, 1'b0);
    send_pair(20'd0, 20'd0, 1'b0);
    send_pair(20'hFFFFF, 20'hFFFFF, 1'b0);
    send_pair(20'd0, 20'hFFFFF, 1'b0);
    send_pair(20'hFFFFF, 20'd0, 1'b0);
    send_pair(20'h55555, 20'hAAAAA, 1'b0);
    send_pair(20'hAAAAA, 20'h55555, 1'b0);
    stop_sending();
    drain();

    // extremes of every coefficient field, all ones, then mixes of 16'h8000, 16'h7FFF and all ones
    write_coef(RegTemp, '1);
    write_coef(RegPressA, '1);
    write_coef(RegPressB, '1);
    write_coef(RegPressC, '1);
    send_pair(20'd0, 20'd0, 1'b0);
    send_pair(20'hFFFFF, 20'hFFFFF, 1'b0);
    send_pair(20'd300000, 20'd600000, 1'b0);
    stop_sending();
    drain();
    write_coef(RegTemp, 48'h8000_7FFF_FFFF);
    write_coef(RegPressA, 48'h7FFF_8000_FFFF);
    write_coef(RegPressB, 48'h8000_7FFF_8000);
    write_coef(RegPressC, 48'h7FFF_8000_7FFF);
    send_pair(20'd0, 20'hFFFFF, 1'b0);
    send_pair(20'hFFFFF, 20'd0, 1'b0);
    send_pair(20'd500000, 20'd400000, 1'b0);
    stop_sending();
    drain();

    // random: mostly realistic calibration, some fully random sets
    for (int phase = 0; phase < 7; phase++) begin
      if (phase % 3 == 2) random_coefs();
      else typical_coefs(phase != 0);
      for (int k = 0; k < 150; k++) begin
        t = 20'($urandom);
        p = 20'($urandom);
        if ($urandom_range(0, 3) != 0) begin
          t = 20'($urandom_range(380000, 640000));
          p = 20'($urandom_range(200000, 700000));
        end
        // stretches with no gaps at all in phase 3
        send_pair(t, p, phase != 3);
      end
      stop_sending();
      drain();
    end

    $display("covered %0d results (%0d with zero divisor) across 11 coefficient sets",
             result_count, invalid_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
